### rtl/etbv_pkg.sv
// ----------------------------------------------------------------------------
// etbv_pkg: shared types and constants for the Euler-to-basis-vector block
// Fixed-point formats, the CORDIC arctangent table and the Q30 multiply.
// ----------------------------------------------------------------------------
package etbv_pkg;

  // Working format: Q30 for sines, cosines and products.
  localparam int WORK_FRAC = 30;
  localparam int TABLE_LEN = 24;
  localparam int XY_W      = 32;
  localparam int Z_W       = 34;

  // CORDIC start magnitude, the inverse gain 0.60725... in Q30.
  localparam logic signed [XY_W-1:0] GAIN_Q30 = 32'sd652032874;

  // One rotation lane: x and y in Q30, residual angle in 2^32-per-turn units.
  typedef struct packed {
    logic signed [XY_W-1:0] x;
    logic signed [XY_W-1:0] y;
    logic signed [Z_W-1:0]  z;
  } lane_t;

  // The three angles travel side by side through the rotation chain.
  typedef struct packed {
    lane_t pitch;
    lane_t yaw;
    lane_t roll;
  } lanes_t;

  // Arctangent of 2^-i in 2^32-per-turn units.
  function automatic logic [31:0] atan_turn(input logic [4:0] idx);
    logic [31:0] r;
    unique case (idx)
      5'd0:    r = 32'd536870912;
      5'd1:    r = 32'd316933406;
      5'd2:    r = 32'd167458907;
      5'd3:    r = 32'd85004756;
      5'd4:    r = 32'd42667331;
      5'd5:    r = 32'd21354465;
      5'd6:    r = 32'd10679838;
      5'd7:    r = 32'd5340245;
      5'd8:    r = 32'd2670163;
      5'd9:    r = 32'd1335087;
      5'd10:   r = 32'd667544;
      5'd11:   r = 32'd333772;
      5'd12:   r = 32'd166886;
      5'd13:   r = 32'd83443;
      5'd14:   r = 32'd41722;
      5'd15:   r = 32'd20861;
      5'd16:   r = 32'd10430;
      5'd17:   r = 32'd5215;
      5'd18:   r = 32'd2608;
      5'd19:   r = 32'd1304;
      5'd20:   r = 32'd652;
      5'd21:   r = 32'd326;
      5'd22:   r = 32'd163;
      5'd23:   r = 32'd81;
      default: r = 32'd0;
    endcase
    return r;
  endfunction

  // Q30 by Q30 product, rounded half up and floored back to Q30.
  function automatic logic signed [XY_W-1:0] qmul(input logic signed [XY_W-1:0] a,
                                                  input logic signed [XY_W-1:0] b);
    logic signed [63:0] p;
    logic signed [63:0] r;
    p = 64'(a) * 64'(b);
    r = (p + (64'sd1 <<< (WORK_FRAC - 1))) >>> WORK_FRAC;
    return r[XY_W-1:0];
  endfunction

endpackage

### rtl/etbv_in_if.sv
// ----------------------------------------------------------------------------
// etbv_in_if: input channel carrying pitch, yaw and roll angles
// Valid/ready stream; a beat moves when valid and ready are both high.
// ----------------------------------------------------------------------------
interface etbv_in_if #(
  parameter int ANGLE_BITS = 16
);
  logic                         valid;
  logic                         ready;
  logic signed [ANGLE_BITS-1:0] pitch_angle;
  logic signed [ANGLE_BITS-1:0] yaw_angle;
  logic signed [ANGLE_BITS-1:0] roll_angle;

  modport source (output valid, output pitch_angle, output yaw_angle,
                  output roll_angle, input ready);
  modport sink   (input valid, input pitch_angle, input yaw_angle,
                  input roll_angle, output ready);
endinterface

### rtl/etbv_out_if.sv
// ----------------------------------------------------------------------------
// etbv_out_if: result channel carrying the forward, right and up vectors
// Valid/ready stream; a beat moves when valid and ready are both high.
// ----------------------------------------------------------------------------
interface etbv_out_if #(
  parameter int OUT_W = 16
);
  logic                    valid;
  logic                    ready;
  logic signed [OUT_W-1:0] fwd_x;
  logic signed [OUT_W-1:0] fwd_y;
  logic signed [OUT_W-1:0] fwd_z;
  logic signed [OUT_W-1:0] rgt_x;
  logic signed [OUT_W-1:0] rgt_y;
  logic signed [OUT_W-1:0] rgt_z;
  logic signed [OUT_W-1:0] up_x;
  logic signed [OUT_W-1:0] up_y;
  logic signed [OUT_W-1:0] up_z;

  modport source (output valid, output fwd_x, output fwd_y, output fwd_z,
                  output rgt_x, output rgt_y, output rgt_z,
                  output up_x, output up_y, output up_z, input ready);
  modport sink   (input valid, input fwd_x, input fwd_y, input fwd_z,
                  input rgt_x, input rgt_y, input rgt_z,
                  input up_x, input up_y, input up_z, output ready);
endinterface

### rtl/etbv_cordic_cell.sv
// ----------------------------------------------------------------------------
// etbv_cordic_cell: one CORDIC micro-rotation for three angle lanes
// Registered stage with its own valid bit; it hands its lanes on each cycle that dn_ready is high.
// ----------------------------------------------------------------------------
module etbv_cordic_cell #(
  parameter int STAGE = 0
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             up_valid,
  output logic             up_ready,
  input  etbv_pkg::lanes_t up_data,
  output logic             dn_valid,
  input  logic             dn_ready,
  output etbv_pkg::lanes_t dn_data
);

  localparam logic signed [etbv_pkg::Z_W-1:0] ATAN =
    etbv_pkg::Z_W'(etbv_pkg::atan_turn(5'(STAGE)));

  logic             valid_r;
  etbv_pkg::lanes_t data_r;
  etbv_pkg::lanes_t data_nxt;

  // One rotation step: direction follows the sign of the residual angle.
  function automatic etbv_pkg::lane_t rotate(input etbv_pkg::lane_t a);
    etbv_pkg::lane_t r;
    logic signed [etbv_pkg::XY_W-1:0] dx;
    logic signed [etbv_pkg::XY_W-1:0] dy;
    dx = a.y >>> STAGE;
    dy = a.x >>> STAGE;
    if (!a.z[etbv_pkg::Z_W-1]) begin
      r.x = a.x - dx;
      r.y = a.y + dy;
      r.z = a.z - ATAN;
    end else begin
      r.x = a.x + dx;
      r.y = a.y - dy;
      r.z = a.z + ATAN;
    end
    return r;
  endfunction

  always_comb begin
    data_nxt.pitch = rotate(up_data.pitch);
    data_nxt.yaw   = rotate(up_data.yaw);
    data_nxt.roll  = rotate(up_data.roll);
  end

  // The stage takes a new beat when it is empty or its beat moves on.
  assign up_ready = !valid_r || dn_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (up_ready) begin
      valid_r <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (up_ready && up_valid) begin
      data_r <= data_nxt;
    end
  end

  assign dn_valid = valid_r;
  assign dn_data  = data_r;

endmodule

### rtl/etbv_basis.sv
// ----------------------------------------------------------------------------
// etbv_basis: products and sums that form the three basis vectors
// Three registered steps: first products, triple products, round and clamp.
// ----------------------------------------------------------------------------
module etbv_basis #(
  parameter int OUT_FRAC_BITS = 14
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             up_valid,
  output logic             up_ready,
  input  etbv_pkg::lanes_t up_data,
  etbv_out_if.source       out_ch
);

  localparam int XW    = etbv_pkg::XY_W;
  localparam int SW    = XW + 2;
  localparam int OUT_W = OUT_FRAC_BITS + 2;
  localparam int SH    = etbv_pkg::WORK_FRAC - OUT_FRAC_BITS;
  localparam logic signed [SW:0] ONE  = (SW+1)'(1) <<< OUT_FRAC_BITS;
  localparam logic signed [SW:0] RND  = (SW+1)'(1) <<< (SH - 1);

  typedef logic signed [XW-1:0] q30_t;

  // First step: single products plus the raw roll and pitch sines and roll cosine still needed later.
  typedef struct packed {
    q30_t sp;
    q30_t sr;
    q30_t cr;
    q30_t sp_cy;
    q30_t sp_sy;
    q30_t cp_cy;
    q30_t cp_sy;
    q30_t sr_cp;
    q30_t cr_cp;
    q30_t cr_sy;
    q30_t cr_cy;
    q30_t sr_sy;
    q30_t sr_cy;
  } prod_a_t;

  // Second step: roll terms applied to the pitch-yaw products.
  typedef struct packed {
    q30_t sp;
    q30_t cp_cy;
    q30_t cp_sy;
    q30_t sr_cp;
    q30_t cr_cp;
    q30_t cr_sy;
    q30_t cr_cy;
    q30_t sr_sy;
    q30_t sr_cy;
    q30_t sr_t;
    q30_t cr_t;
    q30_t sr_u;
    q30_t cr_u;
  } prod_b_t;

  logic    va_r, vb_r, vc_r;
  logic    rdy_a, rdy_b, rdy_c;
  prod_a_t pa_r, pa_nxt;
  prod_b_t pb_r, pb_nxt;

  logic signed [OUT_W-1:0] fx_r, fy_r, fz_r, rx_r, ry_r, rz_r, ux_r, uy_r, uz_r;

  // Round a Q30 sum to the output format and clamp it to plus or minus one.
  function automatic logic signed [OUT_W-1:0] to_out(input logic signed [SW-1:0] v);
    logic signed [SW:0] r;
    logic signed [SW:0] c;
    r = ((SW+1)'(v) + RND) >>> SH;
    if (r > ONE) begin
      c = ONE;
    end else if (r < -ONE) begin
      c = -ONE;
    end else begin
      c = r;
    end
    return c[OUT_W-1:0];
  endfunction

  // Handshake: each step fills when empty or when its beat moves on.
  assign rdy_c    = !vc_r || out_ch.ready;
  assign rdy_b    = !vb_r || rdy_c;
  assign rdy_a    = !va_r || rdy_b;
  assign up_ready = rdy_a;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      va_r <= 1'b0;
      vb_r <= 1'b0;
      vc_r <= 1'b0;
    end else begin
      if (rdy_a) begin
        va_r <= up_valid;
      end
      if (rdy_b) begin
        vb_r <= va_r;
      end
      if (rdy_c) begin
        vc_r <= vb_r;
      end
    end
  end

  // Step one: products of the sines and cosines of pairs of angles.
  always_comb begin
    pa_nxt.sp    = up_data.pitch.y;
    pa_nxt.sr    = up_data.roll.y;
    pa_nxt.cr    = up_data.roll.x;
    pa_nxt.sp_cy = etbv_pkg::qmul(up_data.pitch.y, up_data.yaw.x);
    pa_nxt.sp_sy = etbv_pkg::qmul(up_data.pitch.y, up_data.yaw.y);
    pa_nxt.cp_cy = etbv_pkg::qmul(up_data.pitch.x, up_data.yaw.x);
    pa_nxt.cp_sy = etbv_pkg::qmul(up_data.pitch.x, up_data.yaw.y);
    pa_nxt.sr_cp = etbv_pkg::qmul(up_data.roll.y, up_data.pitch.x);
    pa_nxt.cr_cp = etbv_pkg::qmul(up_data.roll.x, up_data.pitch.x);
    pa_nxt.cr_sy = etbv_pkg::qmul(up_data.roll.x, up_data.yaw.y);
    pa_nxt.cr_cy = etbv_pkg::qmul(up_data.roll.x, up_data.yaw.x);
    pa_nxt.sr_sy = etbv_pkg::qmul(up_data.roll.y, up_data.yaw.y);
    pa_nxt.sr_cy = etbv_pkg::qmul(up_data.roll.y, up_data.yaw.x);
  end

  // Step two: roll sine and cosine times the pitch-yaw products.
  always_comb begin
    pb_nxt.sp    = pa_r.sp;
    pb_nxt.cp_cy = pa_r.cp_cy;
    pb_nxt.cp_sy = pa_r.cp_sy;
    pb_nxt.sr_cp = pa_r.sr_cp;
    pb_nxt.cr_cp = pa_r.cr_cp;
    pb_nxt.cr_sy = pa_r.cr_sy;
    pb_nxt.cr_cy = pa_r.cr_cy;
    pb_nxt.sr_sy = pa_r.sr_sy;
    pb_nxt.sr_cy = pa_r.sr_cy;
    pb_nxt.sr_t  = etbv_pkg::qmul(pa_r.sr, pa_r.sp_cy);
    pb_nxt.cr_t  = etbv_pkg::qmul(pa_r.cr, pa_r.sp_cy);
    pb_nxt.sr_u  = etbv_pkg::qmul(pa_r.sr, pa_r.sp_sy);
    pb_nxt.cr_u  = etbv_pkg::qmul(pa_r.cr, pa_r.sp_sy);
  end

  always_ff @(posedge clk) begin
    if (rdy_a && up_valid) begin
      pa_r <= pa_nxt;
    end
    if (rdy_b && va_r) begin
      pb_r <= pb_nxt;
    end
  end

  // Step three: sums, rounding and clamping into the output register.
  always_ff @(posedge clk) begin
    if (rdy_c && vb_r) begin
      fx_r <= to_out(SW'(pb_r.cp_cy));
      fy_r <= to_out(SW'(pb_r.cp_sy));
      fz_r <= to_out(-SW'(pb_r.sp));
      rx_r <= to_out(SW'(pb_r.cr_sy) - SW'(pb_r.sr_t));
      ry_r <= to_out(-SW'(pb_r.sr_u) - SW'(pb_r.cr_cy));
      rz_r <= to_out(-SW'(pb_r.sr_cp));
      ux_r <= to_out(SW'(pb_r.cr_t) + SW'(pb_r.sr_sy));
      uy_r <= to_out(SW'(pb_r.cr_u) - SW'(pb_r.sr_cy));
      uz_r <= to_out(SW'(pb_r.cr_cp));
    end
  end

  assign out_ch.valid = vc_r;
  assign out_ch.fwd_x = fx_r;
  assign out_ch.fwd_y = fy_r;
  assign out_ch.fwd_z = fz_r;
  assign out_ch.rgt_x = rx_r;
  assign out_ch.rgt_y = ry_r;
  assign out_ch.rgt_z = rz_r;
  assign out_ch.up_x  = ux_r;
  assign out_ch.up_y  = uy_r;
  assign out_ch.up_z  = uz_r;

endmodule

### rtl/euler_to_basis_vectors.sv
// ----------------------------------------------------------------------------
// euler_to_basis_vectors: pitch, yaw and roll to forward, right, up vectors
// A chain of CORDIC cells gives all six sines and cosines; a product
// pipeline forms the nine Q1.14 vector components.
//
//   Channel  Dir  Beat contents
//   in_ch    in   pitch_angle, yaw_angle, roll_angle (binary angles)
//   out_ch   out  fwd_x..up_z, signed Q1.OUT_FRAC_BITS, clamped to +/-1.0
//
// One beat is accepted per cycle while out_ch is not stalled; the path runs
// through the CORDIC cell chain and then the three product steps.
// Every stage has its own valid bit, so bubbles close up while out_ch stalls
// and input keeps flowing until the whole pipeline is full.
// Synchronous active-low reset empties the pipeline; no beat is lost in a stall.
// ----------------------------------------------------------------------------
module euler_to_basis_vectors #(
  parameter int ANGLE_BITS    = 16,
  parameter int OUT_FRAC_BITS = 14,
  parameter int CORDIC_STAGES = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  etbv_in_if.sink     in_ch,
  etbv_out_if.source  out_ch
);

  localparam int NCELL = (CORDIC_STAGES < etbv_pkg::TABLE_LEN) ?
                         CORDIC_STAGES : etbv_pkg::TABLE_LEN;

  logic             cv   [0:NCELL];
  logic             cr   [0:NCELL];
  etbv_pkg::lanes_t cd   [0:NCELL];

  // Place an angle at the top of a 32-bit turn and fold it into the right
  // half-plane, negating the start vector for the second and third quadrants.
  function automatic etbv_pkg::lane_t prep(input logic [ANGLE_BITS-1:0] ang);
    etbv_pkg::lane_t r;
    logic [31:0]     u;
    logic            flip;
    u    = {ang, {(32 - ANGLE_BITS){1'b0}}};
    flip = u[31] ^ u[30];
    if (flip) begin
      u[31] = ~u[31];
      r.x   = -etbv_pkg::GAIN_Q30;
    end else begin
      r.x   = etbv_pkg::GAIN_Q30;
    end
    r.y = '0;
    r.z = etbv_pkg::Z_W'(signed'(u));
    return r;
  endfunction

  // Head of the chain: folded angles straight from the input beat.
  always_comb begin
    cd[0].pitch = prep(in_ch.pitch_angle);
    cd[0].yaw   = prep(in_ch.yaw_angle);
    cd[0].roll  = prep(in_ch.roll_angle);
  end
  assign cv[0]       = in_ch.valid;
  assign in_ch.ready = cr[0];

  // Row of CORDIC cells, one micro-rotation each.
  for (genvar g = 0; g < NCELL; g++) begin : g_cell
    etbv_cordic_cell #(
      .STAGE (g)
    ) u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .up_valid (cv[g]),
      .up_ready (cr[g]),
      .up_data  (cd[g]),
      .dn_valid (cv[g+1]),
      .dn_ready (cr[g+1]),
      .dn_data  (cd[g+1])
    );
  end

  // Products, sums and output register.
  etbv_basis #(
    .OUT_FRAC_BITS (OUT_FRAC_BITS)
  ) u_basis (
    .clk      (clk),
    .rst_n    (rst_n),
    .up_valid (cv[NCELL]),
    .up_ready (cr[NCELL]),
    .up_data  (cd[NCELL]),
    .out_ch   (out_ch)
  );

endmodule

### tb/tb_euler_to_basis_vectors.sv
// ----------------------------------------------------------------------------
// tb_euler_to_basis_vectors: self-checking bench for the Euler-to-basis block
// Drives pitch, yaw and roll angles through the input stream. A bit-exact
// CORDIC and Q30 product model computes the nine vector components of every
// accepted beat. Each result beat is compared with the oldest pending
// prediction. Both stream sides idle and stall at random, and the run also
// includes a long output hold-off and a full drain pause.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_euler_to_basis_vectors;

  localparam int ANG_W     = 16;
  localparam int OUT_FRAC  = 14;
  localparam int N_STAGES  = 16;
  localparam int OUT_W     = OUT_FRAC + 2;
  localparam int DRAIN_CYC = 40;

  // CORDIC start magnitude (inverse gain) in Q30 and result scale one in Q1.14.
  localparam longint CORDIC_START = 64'sd652032874;
  localparam longint Q14_ONE      = 64'sd1 <<< OUT_FRAC;

  // Nine components; index 0 is fwd_x and index 8 is up_z.
  typedef logic [8:0][OUT_W-1:0] basis_t;

  logic clk;
  logic rst_n;

  etbv_in_if  #(.ANGLE_BITS(ANG_W)) in_if ();
  etbv_out_if #(.OUT_W(OUT_W))      out_if ();

  euler_to_basis_vectors #(
    .ANGLE_BITS   (ANG_W),
    .OUT_FRAC_BITS(OUT_FRAC),
    .CORDIC_STAGES(N_STAGES)
  ) i_dut (
    .clk   (clk),
    .rst_n (rst_n),
    .in_ch (in_if),
    .out_ch(out_if)
  );

  // Arctangent of 2^-i, in units where one turn is 2^32.
  longint arctan_turns [24] = '{
    536870912, 316933406, 167458907, 85004756, 42667331, 21354465,
    10679838, 5340245, 2670163, 1335087, 667544, 333772,
    166886, 83443, 41722, 20861, 10430, 5215,
    2608, 1304, 652, 326, 163, 81
  };

  string component_names [9] = '{
    "fwd_x", "fwd_y", "fwd_z", "rgt_x", "rgt_y", "rgt_z", "up_x", "up_y", "up_z"
  };

  basis_t pending_vectors [$];
  int     mismatch_count = 0;
  bit     tx_idle = 1'b1;
  bit     rx_idle = 1'b1;
  int     rx_hold = 0;
  int     rx_stall = 0;

  // Clock.
  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Run limit, far beyond the slowest legal run.
  initial begin
    #5_000_000;
    $display("CHECK FAILED");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Prediction
  // ---------------------------------------------------------------------------

  // Sine and cosine of a binary angle in Q30, by rotation-mode CORDIC.
  function automatic void cordic_sin_cos(input logic [ANG_W-1:0] ang,
                                         output longint sin_q30,
                                         output longint cos_q30);
    logic [31:0] turn;
    longint      x;
    longint      y;
    longint      z;
    longint      dx;
    longint      dy;
    turn = {ang, {(32 - ANG_W){1'b0}}};
    x = CORDIC_START;
    y = 0;
    // Second and third quadrants: rotate by half a turn and flip the start.
    if (turn[31:30] == 2'b01 || turn[31:30] == 2'b10) begin
      turn = turn - 32'h8000_0000;
      x = -CORDIC_START;
    end
    z = $signed(turn);
    for (int i = 0; i < N_STAGES && i < 24; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (z >= 0) begin
        x = x - dx;
        y = y + dy;
        z = z - arctan_turns[i];
      end else begin
        x = x + dx;
        y = y - dy;
        z = z + arctan_turns[i];
      end
    end
    sin_q30 = y;
    cos_q30 = x;
  endfunction

  // Q30 product, rounded half up.
  function automatic longint mul_q30(input longint a, input longint b);
    return (a * b + (64'sd1 <<< 29)) >>> 30;
  endfunction

  // Q30 to Q1.14 with rounding and clamping to +/-1.0.
  function automatic logic [OUT_W-1:0] to_q14(input longint v);
    longint r;
    r = (v + (64'sd1 <<< (29 - OUT_FRAC))) >>> (30 - OUT_FRAC);
    if (r > Q14_ONE) r = Q14_ONE;
    if (r < -Q14_ONE) r = -Q14_ONE;
    return r[OUT_W-1:0];
  endfunction

  function automatic basis_t predict_basis(input logic [ANG_W-1:0] pitch,
                                           input logic [ANG_W-1:0] yaw,
                                           input logic [ANG_W-1:0] roll);
    longint sp, cp, sy, cy, sr, cr;
    longint sp_cy;
    longint sp_sy;
    basis_t v;
    cordic_sin_cos(pitch, sp, cp);
    cordic_sin_cos(yaw, sy, cy);
    cordic_sin_cos(roll, sr, cr);
    sp_cy = mul_q30(sp, cy);
    sp_sy = mul_q30(sp, sy);
    v[0] = to_q14(mul_q30(cp, cy));
    v[1] = to_q14(mul_q30(cp, sy));
    v[2] = to_q14(-sp);
    v[3] = to_q14(-mul_q30(sr, sp_cy) + mul_q30(cr, sy));
    v[4] = to_q14(-mul_q30(sr, sp_sy) - mul_q30(cr, cy));
    v[5] = to_q14(-mul_q30(sr, cp));
    v[6] = to_q14(mul_q30(cr, sp_cy) + mul_q30(sr, sy));
    v[7] = to_q14(mul_q30(cr, sp_sy) - mul_q30(sr, cy));
    v[8] = to_q14(mul_q30(cr, cp));
    return v;
  endfunction

  // ---------------------------------------------------------------------------
  // Stream sides
  // ---------------------------------------------------------------------------

  // Idle length: mostly none, often short, now and then long.
  function automatic int draw_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  // Offers one beat and waits for it to be taken; the prediction is queued
  // at the accepting edge.
  task automatic send_angles(input logic [ANG_W-1:0] pitch,
                             input logic [ANG_W-1:0] yaw,
                             input logic [ANG_W-1:0] roll);
    int gap;
    gap = tx_idle ? draw_gap() : 0;
    if (gap > 0) begin
      in_if.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_if.valid       <= 1'b1;
    in_if.pitch_angle <= pitch;
    in_if.yaw_angle   <= yaw;
    in_if.roll_angle  <= roll;
    do @(posedge clk); while (!in_if.ready);
    pending_vectors.push_back(predict_basis(pitch, yaw, roll));
  endtask

  // Holds the input idle until every pending result has come out.
  task automatic wait_drained();
    in_if.valid <= 1'b0;
    while (pending_vectors.size() != 0) @(posedge clk);
  endtask

  // Output ready: a requested hold-off first, then random stalls when enabled.
  initial begin : result_ready
    logic ready_next;
    out_if.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (!rst_n) begin
        ready_next = 1'b0;
      end else if (rx_hold > 0) begin
        rx_hold--;
        ready_next = 1'b0;
      end else if (rx_stall > 0) begin
        rx_stall--;
        ready_next = 1'b0;
      end else if (!rx_idle || $urandom_range(0, 99) < 70) begin
        ready_next = 1'b1;
      end else begin
        rx_stall = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40)
                                               : $urandom_range(0, 2);
        ready_next = 1'b0;
      end
      out_if.ready <= ready_next;
    end
  end

  // Compares every result beat with the oldest prediction.
  basis_t got_vec;
  basis_t want_vec;

  always @(posedge clk) begin
    if (rst_n && out_if.valid && out_if.ready) begin
      got_vec = {out_if.up_z, out_if.up_y, out_if.up_x,
                 out_if.rgt_z, out_if.rgt_y, out_if.rgt_x,
                 out_if.fwd_z, out_if.fwd_y, out_if.fwd_x};
      if (pending_vectors.size() == 0) begin
        $display("%0t: result beat with none pending, fwd_x=%0d", $time,
                 $signed(got_vec[0]));
        mismatch_count++;
      end else begin
        want_vec = pending_vectors.pop_front();
        for (int k = 0; k < 9; k++) begin
          if (got_vec[k] !== want_vec[k]) begin
            $display("%0t: %s expected %0d, actual %0d", $time, component_names[k],
                     $signed(want_vec[k]), $signed(got_vec[k]));
            mismatch_count++;
          end
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Field extremes and the quadrant boundaries, where the CORDIC start flips
  // and the cosine overshoot must clamp at one.
  task automatic test_directed_angles();
    logic [ANG_W-1:0] corner [11];
    corner = '{16'h0000, 16'h4000, 16'h8000, 16'hC000, 16'h7FFF, 16'hFFFF,
               16'h0001, 16'h2000, 16'h3FFF, 16'hBFFF, 16'h4001};
    for (int i = 0; i < 11; i++) begin
      send_angles(corner[i], corner[i], corner[i]);
      send_angles(corner[i], ~corner[i], corner[(i + 3) % 11]);
    end
  endtask

  // Uniform random angles with idling on both sides.
  task automatic test_random_angles(input int count);
    for (int i = 0; i < count; i++)
      send_angles(ANG_W'($urandom_range(0, 65535)), ANG_W'($urandom_range(0, 65535)),
                  ANG_W'($urandom_range(0, 65535)));
  endtask

  // Angles close to the axes, so sines and cosines sit near the clamp.
  task automatic test_near_axes(input int count);
    logic [ANG_W-1:0] a [3];
    for (int i = 0; i < count; i++) begin
      for (int j = 0; j < 3; j++)
        a[j] = {2'($urandom_range(0, 3)), 14'h0} + ANG_W'($urandom_range(0, 64))
               - ANG_W'(32);
      send_angles(a[0], a[1], a[2]);
    end
  endtask

  // The output holds off for a long stretch while beats keep coming, so the
  // pipeline fills and the input stalls.
  task automatic test_full_pipeline();
    tx_idle = 1'b0;
    rx_hold = 250;
    test_random_angles(60);
    tx_idle = 1'b1;
  endtask

  // A burst, a full drain, then a second burst into an empty pipeline.
  task automatic test_drain_pause();
    test_random_angles(20);
    wait_drained();
    test_near_axes(20);
  endtask

  // Back-to-back beats with both sides always ready.
  task automatic test_streaming(input int count);
    tx_idle = 1'b0;
    rx_idle = 1'b0;
    test_random_angles(count);
    tx_idle = 1'b1;
    rx_idle = 1'b1;
  endtask

  // ---------------------------------------------------------------------------
  // Sequence
  // ---------------------------------------------------------------------------

  initial begin
    rst_n             <= 1'b0;
    in_if.valid       <= 1'b0;
    in_if.pitch_angle <= '0;
    in_if.yaw_angle   <= '0;
    in_if.roll_angle  <= '0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_directed_angles();
    test_random_angles(300);
    test_full_pipeline();
    test_drain_pause();
    test_near_axes(180);
    test_streaming(100);

    wait_drained();
    repeat (DRAIN_CYC) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
